[rtl/assert_macros.svh]
// Assertion macros for the port-level checker of the primality tester.
// Depends on nothing; expects signals clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define TDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdp check failed");

// Next-cycle implication, clocked on clk, off during reset
`define TDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdp check failed");

`endif

[rtl/tdp_pkg.sv]
// Shared types and constants for the trial-division primality tester.
// Depends on nothing; used by every module of the block.
package tdp_pkg;

    // Default width of the tested value
    localparam int VALUE_WIDTH_DEF = 20;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BOUND,
        ST_DIVIDE,
        ST_FINISH
    } tdp_state_t;

    // Status from the remainder unit to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } tdp_rem_sts_t;

endpackage

[rtl/tdp_rem_unit.sv]
// Bit-serial remainder unit: value mod divisor, one dividend bit per cycle.
// Depends on tdp_pkg for the status struct.
module tdp_rem_unit #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF,
    parameter int DIV_WIDTH   = VALUE_WIDTH / 2 + 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [VALUE_WIDTH-1:0]   dividend,
    input  logic [DIV_WIDTH-1:0]     divisor,
    output tdp_pkg::tdp_rem_sts_t    sts
);
    import tdp_pkg::*;

    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [DIV_WIDTH-1:0]   dsr_reg, dsr_next;
    logic [DIV_WIDTH:0]     rem_sh;
    logic [DIV_WIDTH:0]     rem_sub;

    // Shift in the next dividend bit and subtract the divisor where it fits
    always_comb
    begin
        rem_sh  = {rem_reg, shift_reg[VALUE_WIDTH-1]};
        rem_sub = rem_sh - {1'b0, dsr_reg};
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_WIDTH'(VALUE_WIDTH);
            shift_next = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next   = cnt_reg - CNT_WIDTH'(1);
            if (rem_sh >= {1'b0, dsr_reg})
                rem_next = rem_sub[DIV_WIDTH-1:0];
            else
                rem_next = rem_sh[DIV_WIDTH-1:0];
            if (cnt_reg == CNT_WIDTH'(1))
                busy_next = 1'b0;
        end
    end

    // Report on the last bit, with the final remainder as it is formed
    always_comb
    begin
        sts.done     = busy_reg && (cnt_reg == CNT_WIDTH'(1));
        sts.rem_zero = (rem_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
    end

endmodule

[rtl/trial_division_prime_test.sv]
// Top level of the trial-division primality tester: sequencer and stream ports.
// Depends on tdp_pkg and tdp_rem_unit.
//
//  channel | dir | fields (tdata, low bit first)
//  s_axis  | in  | value [VALUE_WIDTH-1:0], padded to whole bytes, padding ignored
//  m_axis  | out | is_prime [0], zero padded to 8 bits
//
// Each trial divisor d takes a bound check, then the remainder of the value
// by d, one bit per cycle in the serial remainder unit. A prime v is tried
// with every divisor from 2 up to isqrt(v); a composite stops at its smallest
// factor p. Values below two go straight to the verdict, without division.
// One request is in work at a time; a finished result waits in the output
// register, and a new request is taken meanwhile. Reset clears all control.
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]   s_tdata,  // value
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata   // is_prime
);
    import tdp_pkg::*;

    localparam int DIV_WIDTH = VALUE_WIDTH / 2 + 2;
    localparam int SQ_WIDTH  = VALUE_WIDTH + 2;

    tdp_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [DIV_WIDTH-1:0]   div_reg, div_next;
    logic [SQ_WIDTH-1:0]    sq_reg, sq_next;
    logic                   prime_reg, prime_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_data_reg, out_data_next;
    logic                   in_acc;
    logic                   out_free;
    logic                   over_bound;
    logic                   rem_start;
    tdp_rem_sts_t           rem_sts;

    assign in_acc     = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign over_bound = sq_reg > {2'b00, value_reg};

    // Serial remainder of value by the current trial divisor
    tdp_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DIV_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (value_reg),
        .divisor  (div_reg),
        .sts      (rem_sts)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tdata[VALUE_WIDTH-1:1] == '0)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                if (over_bound)
                    state_next = ST_FINISH;
                else
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (rem_sts.done)
                begin
                    if (rem_sts.rem_zero)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_BOUND;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs per state
    always_comb
    begin
        s_tready       = 1'b0;
        rem_start      = 1'b0;
        value_next     = value_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                value_next = s_tdata[VALUE_WIDTH-1:0];
                div_next   = DIV_WIDTH'(2);
                sq_next    = SQ_WIDTH'(4);
                prime_next = 1'b0;
            end
            ST_BOUND:
            begin
                // No divisor up to the square root left: prime
                if (over_bound)
                    prime_next = 1'b1;
                else
                    rem_start = 1'b1;
            end
            ST_DIVIDE:
            begin
                // Advance to d + 1: (d + 1)^2 = d^2 + 2d + 1
                if (rem_sts.done && !rem_sts.rem_zero)
                begin
                    sq_next  = sq_reg + SQ_WIDTH'({div_reg, 1'b1});
                    div_next = div_reg + DIV_WIDTH'(1);
                end
            end
            ST_FINISH:
            begin
                // Hold the verdict until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = prime_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        div_reg      <= div_next;
        sq_reg       <= sq_next;
        prime_reg    <= prime_next;
        out_data_reg <= out_data_next;
    end

endmodule

[rtl/tdp_checker.sv]
// Port-level checker for the primality tester, bound onto the top level.
// Depends on assert_macros.svh and tdp_pkg.
`include "assert_macros.svh"

module tdp_checker #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,  // value
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [7:0]                       m_tdata   // is_prime
);
    import tdp_pkg::*;

    // One request in work at a time: intake closes after each request
    `TDP_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready)

    // Only the verdict bit may be set
    `TDP_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7:1] == 7'b0)

    // A stalled result stays offered
    `TDP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // A stalled result keeps its value
    `TDP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind trial_division_prime_test tdp_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_tdp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/prime_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the trial-division primality tester: watches both stream
// channels, predicts each verdict by trial division and compares in order.
// Depends on tdp_pkg for the default value width.
module prime_result_checker #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,  // value
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [7:0]                       m_tdata,  // is_prime
    output int                               failures,
    output int                               pending
);

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        logic                   is_prime;
    } verdict_t;

    // Verdicts still owed by the block, oldest first
    verdict_t expected_verdicts[$];

    // Try every divisor whose square does not exceed the value
    function automatic logic trial_divide_prime(input logic [VALUE_WIDTH-1:0] value);
        longint unsigned wide;
        longint unsigned divisor;
        wide = value;
        if (wide < 2)
            return 1'b0;
        for (divisor = 2; divisor * divisor <= wide; divisor++)
        begin
            if (wide % divisor == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        verdict_t req;
        verdict_t owed;
        if (rst_n)
        begin
            // Match a delivered verdict against the oldest one owed
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("is_prime %0b delivered with no request outstanding", m_tdata[0]);
                    failures++;
                end
                else
                begin
                    owed = expected_verdicts.pop_front();
                    if (m_tdata[0] !== owed.is_prime)
                    begin
                        $error("is_prime for value %0d: expected %0b, actual %0b",
                               owed.value, owed.is_prime, m_tdata[0]);
                        failures++;
                    end
                end
            end
            // Record the verdict for each accepted request; padding bits are ignored
            if (s_tvalid && s_tready)
            begin
                req.value    = s_tdata[VALUE_WIDTH-1:0];
                req.is_prime = trial_divide_prime(req.value);
                expected_verdicts.push_back(req);
            end
            pending <= expected_verdicts.size();
        end
    end

endmodule

[tb/trial_division_prime_test_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the trial-division primality tester: clock, reset, request
// stimulus and back-pressure; prime_result_checker does the comparison.
// Depends on tdp_pkg, trial_division_prime_test and prime_result_checker.
module trial_division_prime_test_tb;

    import tdp_pkg::*;

    localparam int VALUE_WIDTH       = VALUE_WIDTH_DEF;
    localparam int DATA_WIDTH        = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_PER_PHASE  = 21;
    localparam int PRESSURE_REQUESTS = 6;
    localparam int LONG_HOLD_CYCLES  = 600;
    localparam int DRAIN_LIMIT       = 100000;
    localparam int SETTLE_CYCLES     = 100;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_WIDTH-1:0] s_tdata  = '0;     // value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;           // is_prime

    int failures;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_request  = 1'b0;

    // Edge values, small and large primes, squares of primes, a composite with a large
    // smallest factor (square of a prime just above a thousand) and alternating bits
    int unsigned directed_values [19] = '{
        0, 1, 2, 3, 4, 5, 9, 25, 49, 97, 121, 65537, 524288,
        699050, 349525, 1048575, 1048573, 999983, 1018081
    };

    always #2 clk = ~clk;

    trial_division_prime_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    prime_result_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) verdict_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .failures (failures),
        .pending  (pending)
    );

    // Offer one request after a random gap and hold it until accepted
    task automatic offer_value(input logic [VALUE_WIDTH-1:0] value,
                               input logic [DATA_WIDTH-1:0]  pad_fill);
        logic [DATA_WIDTH-1:0] word;
        word = pad_fill;
        word[VALUE_WIDTH-1:0] = value;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop the request and wait until every owed verdict has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        for (int i = 0; pending != 0 && i < DRAIN_LIMIT; i++)
            @(posedge clk);
    endtask

    // Receiver: random stalls, or one long hold-off when asked
    initial
    begin
        int hold_count;
        bit hold_done;
        hold_count = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_count == 0 && hold_request && !hold_done)
            begin
                hold_count = LONG_HOLD_CYCLES;
                hold_done  = 1'b1;
            end
            if (hold_count > 0)
            begin
                m_tready <= 1'b0;
                hold_count--;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [VALUE_WIDTH-1:0] value;
        logic [DATA_WIDTH-1:0]  pad_fill;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests, then values with the padding bits set
        foreach (directed_values[i])
            offer_value(VALUE_WIDTH'(directed_values[i]), '0);
        offer_value(VALUE_WIDTH'(7), '1);
        offer_value(VALUE_WIDTH'(4), '1);
        wait_for_results();

        // Hold the receiver off long enough for the block to stall its input
        hold_request = 1'b1;
        for (int n = 0; n < PRESSURE_REQUESTS; n++)
            offer_value(VALUE_WIDTH'($urandom_range(60, 2)), '0);
        wait_for_results();

        // Random requests: mostly small values, a few across the whole range
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if ($urandom_range(9) == 0)
                    value = VALUE_WIDTH'($urandom);
                else
                    value = VALUE_WIDTH'($urandom_range(4095));
                pad_fill = ($urandom_range(7) == 0) ? DATA_WIDTH'($urandom) : '0;
                offer_value(value, pad_fill);
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("All tests passed");
        else
        begin
            if (pending != 0)
                $error("%0d is_prime verdicts never delivered", pending);
            $display("Some tests failed");
        end
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
